@@ rtl/ckbg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ckbg_pkg;

  // Field widths
  localparam int ColorW  = 16;
  localparam int OriginW = 10;
  localparam int DimW    = 8;
  localparam int CoordW  = 11;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 10;
  localparam int TdataW  = 40;

  // Transparent key color (magenta)
  localparam logic [ColorW-1:0] KeyColor = 16'hF81F;

  // Reset geometry
  localparam logic [DimW-1:0] ResetWidth  = 8'd16;
  localparam logic [DimW-1:0] ResetHeight = 8'd16;

  // Reciprocal of 100 scaled by 2^19; exact for weighted sums below 25600.
  localparam logic [12:0] Recip100 = 13'd5243;
  localparam int          RecipShift = 19;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_ORIGIN_X      = 3'd0,
    REG_ORIGIN_Y      = 3'd1,
    REG_SPRITE_WIDTH  = 3'd2,
    REG_SPRITE_HEIGHT = 3'd3,
    REG_GRAY_MODE     = 3'd4
  } reg_idx_t;

  // One result item
  typedef struct packed {
    logic                     write_enable;
    logic signed [CoordW-1:0] pixel_x;
    logic signed [CoordW-1:0] pixel_y;
    logic [ColorW-1:0]        out_color;
    logic                     sprite_last;
  } result_t;

  // Red channel expanded to 8 bits and weighted by 30.
  function automatic logic [0:31] [12:0] red_weight_table();
    logic [0:31] [12:0] t;
    for (int i = 0; i < 32; i++) begin
      t[i] = 13'(((i * 255) / 31) * 30);
    end
    return t;
  endfunction

  // Green channel expanded to 8 bits and weighted by 59.
  function automatic logic [0:63] [13:0] green_weight_table();
    logic [0:63] [13:0] t;
    for (int i = 0; i < 64; i++) begin
      t[i] = 14'(((i * 255) / 63) * 59);
    end
    return t;
  endfunction

  // Blue channel expanded to 8 bits and weighted by 11.
  function automatic logic [0:31] [11:0] blue_weight_table();
    logic [0:31] [11:0] t;
    for (int i = 0; i < 32; i++) begin
      t[i] = 12'(((i * 255) / 31) * 11);
    end
    return t;
  endfunction

  localparam logic [0:31] [12:0] RedWeight   = red_weight_table();
  localparam logic [0:63] [13:0] GreenWeight = green_weight_table();
  localparam logic [0:31] [11:0] BlueWeight  = blue_weight_table();

endpackage

`default_nettype wire

@@ rtl/color_key_sprite_blit_gray.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Transaction contents
// s_axis    in         tdata[15:0] pixel_color
// m_axis    out        tdata: pixel_x, pixel_y, out_color; tuser: write_enable;
//                      tlast: sprite_last
// cfg       in         one register write per cycle with cfg_we high
// One pixel is accepted per clock while tready is high; its screen write is
// registered in the result register, or in the skid register during a stall.
// The table lookups, the weighted sum and one multiply by the reciprocal of 100
// sit between the input port and the result register. A skid register holds
// one extra result, so input is taken even while the current result is
// stalled; tready drops only when the skid register is full. Reset clears the
// counters, valid flags, origins and gray mode and sets a 16 x 16 sprite size.

module color_key_sprite_blit_gray
  import ckbg_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // Configuration
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [CfgW-1:0]    cfg_data,
  // Sprite pixel input
  input  wire logic               s_axis_tvalid,
  output      logic               s_axis_tready,
  input  wire logic [ColorW-1:0]  s_axis_tdata,   // pixel_color[15:0]
  // Screen write output
  output      logic               m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output      logic [TdataW-1:0]  m_axis_tdata,   // pixel_x[10:0], pixel_y[21:11],
                                                  // out_color[37:22], zero[39:38]
  output      logic               m_axis_tuser,   // write_enable
  output      logic               m_axis_tlast    // sprite_last
);

  // Configuration registers
  logic signed [OriginW-1:0] origin_x;
  logic signed [OriginW-1:0] origin_y;
  logic [DimW-1:0]           sprite_width;
  logic [DimW-1:0]           sprite_height;
  logic                      gray_mode;

  // Sprite walk counters
  logic [DimW-1:0] column_count;
  logic [DimW-1:0] row_count;
  logic [DimW-1:0] column_count_next;
  logic [DimW-1:0] row_count_next;

  // Output and skid registers
  result_t main_res;
  result_t skid_res;
  logic    main_valid;
  logic    skid_valid;

  logic    in_accept;
  logic    main_free;
  logic    row_end;
  logic    last_row;
  result_t new_res;

  // Gray conversion path
  logic [ColorW-1:0] pix;
  logic              opaque;
  logic [14:0]       weight_sum;
  logic [27:0]       scaled;
  logic [7:0]        luma;
  logic [ColorW-1:0] gray565;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x      <= '0;
      origin_y      <= '0;
      sprite_width  <= ResetWidth;
      sprite_height <= ResetHeight;
      gray_mode     <= 1'b0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ORIGIN_X:      origin_x      <= cfg_data;
        REG_ORIGIN_Y:      origin_y      <= cfg_data;
        REG_SPRITE_WIDTH:  sprite_width  <= cfg_data[DimW-1:0];
        REG_SPRITE_HEIGHT: sprite_height <= cfg_data[DimW-1:0];
        REG_GRAY_MODE:     gray_mode     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !skid_valid;
  assign in_accept     = s_axis_tvalid && !skid_valid;
  assign main_free     = !main_valid || m_axis_tready;

  // Position in the sprite; a zero bound behaves as one.
  always_comb begin
    row_end  = ({1'b0, column_count} + 9'd1) >= {1'b0, sprite_width};
    last_row = ({1'b0, row_count} + 9'd1) >= {1'b0, sprite_height};
    if (row_end) begin
      column_count_next = '0;
      row_count_next    = last_row ? '0 : row_count + 8'd1;
    end else begin
      column_count_next = column_count + 8'd1;
      row_count_next    = row_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // Luma: expanded channels are pre-weighted in the tables, then divided by 100.
  always_comb begin
    pix        = s_axis_tdata;
    opaque     = (pix != KeyColor);
    weight_sum = 15'(RedWeight[pix[15:11]]) + 15'(GreenWeight[pix[10:5]])
               + 15'(BlueWeight[pix[4:0]]);
    scaled     = 28'(weight_sum) * 28'(Recip100);
    luma       = scaled[RecipShift+7:RecipShift];
    gray565    = {luma[7:3], luma[7:2], luma[7:3]};
  end

  // Result of the pixel on the input port
  always_comb begin
    new_res.write_enable = opaque;
    new_res.pixel_x      = {origin_x[OriginW-1], origin_x}
                         + $signed({3'b000, column_count});
    new_res.pixel_y      = {origin_y[OriginW-1], origin_y}
                         + $signed({3'b000, row_count});
    new_res.out_color    = !opaque ? '0 : (gray_mode ? gray565 : pix);
    new_res.sprite_last  = row_end && last_row;
  end

  // Result register with a skid stage behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (main_free) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= in_accept;
      end
    end else if (in_accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (main_free) begin
      if (skid_valid) begin
        main_res <= skid_res;
      end else if (in_accept) begin
        main_res <= new_res;
      end
    end else if (in_accept) begin
      skid_res <= new_res;
    end
  end

  // Output packing
  assign m_axis_tvalid = main_valid;
  assign m_axis_tdata  = {2'b00, main_res.out_color, main_res.pixel_y, main_res.pixel_x};
  assign m_axis_tuser  = main_res.write_enable;
  assign m_axis_tlast  = main_res.sprite_last;

endmodule

`default_nettype wire

@@ rtl/ckbg_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ckbg_checker
  import ckbg_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               s_axis_tready,
  input wire logic               m_axis_tvalid,
  input wire logic               m_axis_tready,
  input wire logic [TdataW-1:0]  m_axis_tdata,
  input wire logic               m_axis_tuser,
  input wire logic               m_axis_tlast
);

  // No result is presented right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // Input stalls only when a result is already waiting on the output.
  a_stall_has_result: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no pending result");

  // A transparent pixel carries a zero color.
  a_transparent_black: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[37:22] == '0))
    else $error("transparent pixel with nonzero color");

  // A stalled transaction keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
       && $stable(m_axis_tlast)))
    else $error("stalled result changed");

endmodule

bind color_key_sprite_blit_gray ckbg_checker u_ckbg_checker (.*);

`default_nettype wire
